/* rtl/core/crcrp_pkg.sv */
// ----------------------------------------------------------------------------
// crcrp_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// record frame parser.
// ----------------------------------------------------------------------------
package crcrp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = 7;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 8;
    localparam int CRC_W       = 16;
    localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

    typedef enum logic [5:0] {
        PH_COUNT   = 6'b000001,
        PH_LENGTH  = 6'b000010,
        PH_PAYLOAD = 6'b000100,
        PH_CRC_LO  = 6'b001000,
        PH_CRC_HI  = 6'b010000,
        PH_DRAIN   = 6'b100000
    } t_phase;

    // Request from the parser to start emitting one accepted record.
    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } t_emit_req;

    // Write port of the payload store.
    typedef struct packed {
        logic              wr_en;
        logic [PAY_AW-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } t_store_wr;

    function automatic logic [CRC_W-1:0] crc16_update(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((crc & CRC_MSB) != '0) begin
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[CRC_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/core/crcrp_ram.sv */
// ----------------------------------------------------------------------------
// crcrp_ram
// Payload store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crcrp_ram
    import crcrp_pkg::*;
(
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  logic              i_rd_en,
    input  logic [PAY_AW-1:0] i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_mem[i_wr.wr_addr] <= i_wr.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/crcrp_parser.sv */
// ----------------------------------------------------------------------------
// crcrp_parser
// Byte-level frame parser: count, length, payload, CRC bytes. Writes payload
// into the store and asks the emitter to send out a record that passes.
// ----------------------------------------------------------------------------
module crcrp_parser
    import crcrp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [ADDR_W-1:0] i_slave_address,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_end_of_transfer,
    output t_store_wr         o_wr,
    output t_emit_req         o_req
);

    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0] MAX_BYTE = BYTE_W'(MAX_PAYLOAD);

    t_phase            r_phase,  n_phase;
    logic [CNT_W-1:0]  r_left,   n_left;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [LEN_W-1:0]  r_taken,  n_taken;
    logic [CRC_W-1:0]  r_crc,    n_crc;
    logic [BYTE_W-1:0] r_crc_lo, n_crc_lo;
    logic [CNT_W-1:0]  left_dec;

    assign left_dec = r_left - CNT_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_len    = r_len;
        n_taken  = r_taken;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        o_wr     = '0;
        o_req    = '0;
        if (i_accept) begin
            case (r_phase)
                PH_COUNT: begin
                    if (i_rx_byte == '0) begin
                        n_phase = PH_DRAIN;
                    end else begin
                        n_left  = i_rx_byte;
                        n_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (i_rx_byte > MAX_BYTE) begin
                        n_phase = PH_DRAIN;
                    end else begin
                        n_len   = i_rx_byte[LEN_W-1:0];
                        n_taken = '0;
                        n_crc   = CRC_INIT;
                        n_phase = (i_rx_byte[LEN_W-1:0] == '0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_taken < r_len && r_taken < MAX_LEN) begin
                        o_wr.wr_en   = 1'b1;
                        o_wr.wr_addr = r_taken[PAY_AW-1:0];
                        o_wr.wr_data = i_rx_byte;
                        n_crc        = crc16_update(r_crc, i_rx_byte);
                        n_taken      = r_taken + LEN_W'(1);
                    end
                    if (n_taken >= r_len) begin
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    n_crc_lo = i_rx_byte;
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    if ({i_rx_byte, r_crc_lo} != r_crc) begin
                        n_phase = PH_DRAIN;
                    end else begin
                        o_req.start = 1'b1;
                        o_req.addr  = i_slave_address;
                        o_req.len   = r_len;
                        n_left      = left_dec;
                        n_phase     = (left_dec == '0) ? PH_DRAIN : PH_LENGTH;
                    end
                end
                default: begin
                    n_phase = PH_DRAIN;
                end
            endcase
            // The final byte of a transfer always rearms the parser.
            if (i_end_of_transfer) begin
                n_phase  = PH_COUNT;
                n_left   = '0;
                n_len    = '0;
                n_taken  = '0;
                n_crc    = CRC_INIT;
                n_crc_lo = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COUNT;
            r_left   <= '0;
            r_len    <= '0;
            r_taken  <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_len    <= n_len;
            r_taken  <= n_taken;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

/* rtl/core/crcrp_emit.sv */
// ----------------------------------------------------------------------------
// crcrp_emit
// Reads a passed record out of the payload store and presents it on the
// output register, one byte per transaction, or a single empty-record marker.
// ----------------------------------------------------------------------------
module crcrp_emit
    import crcrp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_emit_req         i_req,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_rd_en,
    output logic [PAY_AW-1:0] o_rd_addr,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ADDR_W-1:0] o_source_address,
    output logic [LEN_W-1:0]  o_record_length,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_last_of_record
);

    logic              r_active, n_active;
    logic [LEN_W-1:0]  r_idx,    n_idx;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [ADDR_W-1:0] r_addr,   n_addr;
    logic              r_pend,   n_pend;
    logic              r_pend_last, n_pend_last;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_out_addr,  n_out_addr;
    logic [LEN_W-1:0]  r_out_len,   n_out_len;
    logic [BYTE_W-1:0] r_out_data,  n_out_data;
    logic              r_out_last,  n_out_last;
    logic              out_free;
    logic [LEN_W-1:0]  idx_inc;

    assign out_free = !r_out_valid || !i_stall;
    assign idx_inc  = r_idx + LEN_W'(1);

    always_comb begin
        n_active    = r_active;
        n_idx       = r_idx;
        n_len       = r_len;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid && i_stall;
        n_out_addr  = r_out_addr;
        n_out_len   = r_out_len;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx[PAY_AW-1:0];

        // A read issued last cycle only ever finds the output register free.
        if (r_pend) begin
            n_out_valid = 1'b1;
            n_out_addr  = r_addr;
            n_out_len   = r_len;
            n_out_data  = i_rd_data;
            n_out_last  = r_pend_last;
        end

        if (r_active && out_free && !r_pend) begin
            if (r_len == '0) begin
                n_out_valid = 1'b1;
                n_out_addr  = r_addr;
                n_out_len   = '0;
                n_out_data  = '0;
                n_out_last  = 1'b1;
                n_active    = 1'b0;
            end else begin
                o_rd_en     = 1'b1;
                n_pend      = 1'b1;
                n_pend_last = (idx_inc == r_len);
                n_idx       = idx_inc;
                n_active    = (idx_inc != r_len);
            end
        end

        if (i_req.start) begin
            n_active = 1'b1;
            n_idx    = '0;
            n_len    = i_req.len;
            n_addr   = i_req.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_addr      <= n_addr;
        r_pend_last <= n_pend_last;
        r_out_addr  <= n_out_addr;
        r_out_len   <= n_out_len;
        r_out_data  <= n_out_data;
        r_out_last  <= n_out_last;
    end

    assign o_busy           = r_active || r_pend;
    assign o_valid          = r_out_valid;
    assign o_source_address = r_out_addr;
    assign o_record_length  = r_out_len;
    assign o_data_byte      = r_out_data;
    assign o_last_of_record = r_out_last;

endmodule

/* rtl/core/crc16_record_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// crc16_record_frame_parser_unit
// Parses length-prefixed records with a little-endian CRC-16/CCITT-FALSE
// trailer and sends out the payload of each record that passes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | i_valid / o_stall  | slave_address, rx_byte, end_of_transfer
//  out     | output    | o_valid / i_stall  | source_address, record_length,
//          |           |                    | data_byte, last_of_record
//
// A received byte is taken while no record is being emitted.
// After the high CRC byte of a passing record the input is held off while the
// payload store is read out: each byte takes one store read and then one output
// load, and the next read waits for that load; an empty record gives one marker.
// Output stalls lengthen the read-out. Reset is synchronous and clears the parser
// and the output stage; the payload store needs no clearing.
// ----------------------------------------------------------------------------
module crc16_record_frame_parser_unit
    import crcrp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ADDR_W-1:0] i_slave_address,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_end_of_transfer,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ADDR_W-1:0] o_source_address,
    output logic [LEN_W-1:0]  o_record_length,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_last_of_record
);

    logic              busy;
    logic              accept;
    t_store_wr         store_wr;
    t_emit_req         emit_req;
    logic              rd_en;
    logic [PAY_AW-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    crcrp_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_slave_address  (i_slave_address),
        .i_rx_byte        (i_rx_byte),
        .i_end_of_transfer(i_end_of_transfer),
        .o_wr             (store_wr),
        .o_req            (emit_req)
    );

    crcrp_ram u_ram (
        .i_clk    (i_clk),
        .i_wr     (store_wr),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    crcrp_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (emit_req),
        .i_rd_data       (rd_data),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_source_address(o_source_address),
        .o_record_length (o_record_length),
        .o_data_byte     (o_data_byte),
        .o_last_of_record(o_last_of_record)
    );

endmodule

/* rtl/core/crcrp_checker.sv */
// ----------------------------------------------------------------------------
// crcrp_checker
// Port-level checks for the record frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module crcrp_checker
    import crcrp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [ADDR_W-1:0] i_slave_address,
    input logic [BYTE_W-1:0] i_rx_byte,
    input logic              i_end_of_transfer,
    input logic              o_valid,
    input logic              i_stall,
    input logic [ADDR_W-1:0] o_source_address,
    input logic [LEN_W-1:0]  o_record_length,
    input logic [BYTE_W-1:0] o_data_byte,
    input logic              o_last_of_record
);

    // A stalled input transaction holds its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_rx_byte)
            && $stable(i_slave_address) && $stable(i_end_of_transfer))
        else $error("stalled input changed");

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_byte)
            && $stable(o_source_address) && $stable(o_last_of_record))
        else $error("stalled result changed");

    // The empty-record marker is a single, final result with a zero byte.
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_length == '0 |-> o_last_of_record && o_data_byte == '0)
        else $error("malformed empty-record marker");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_record_length <= LEN_W'(MAX_PAYLOAD))
        else $error("record length above maximum");

    // No result is presented straight after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind crc16_record_frame_parser_unit crcrp_checker u_crcrp_checker (.*);
